/* rtl/marching_squares_cell_mesher_unit_defines.svh */
// assertion macros used by the mesher back end
`ifndef MARCHING_SQUARES_CELL_MESHER_UNIT_DEFINES_SVH
`define MARCHING_SQUARES_CELL_MESHER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define MSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define MSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/msq_pkg.sv */
package msq_pkg;

    // grid and vertex numbering
    localparam int GRID_SIZE  = 256;
    localparam int INDEX_BITS = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_TILE_SIZE     = 2'd0;
    localparam logic [1:0] CFG_WALL_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_FRACTION = 2'd2;

    // record kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    localparam logic [25:0] POS_MAX = 26'h3FFFFFF;

    // corner and edge points of a cell
    typedef enum logic [2:0] {
        PT_BL, PT_BR, PT_TR, PT_TL, PT_BOT, PT_RIGHT, PT_TOP, PT_LEFT
    } point_t;

    typedef struct packed {
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [3:0] corner_walls;
        logic       new_mesh;
    } cell_t;

    typedef struct packed {
        logic        kind;
        logic [25:0] pos_x;
        logic [25:0] pos_y;
        logic [23:0] pos_z;
        logic        uv_top;
        logic [23:0] index_a;
        logic [23:0] index_b;
        logic [23:0] index_c;
        logic        index_overflow;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [9:0]  tile_size;
        logic [15:0] wall_height;
        logic [8:0]  edge_fraction;
    } cfg_t;

    // one classified cell waiting for the back end
    typedef struct packed {
        logic [7:0]            cell_x;
        logic [7:0]            cell_y;
        logic [3:0]            walls;
        logic [2:0]            count;
        logic [INDEX_BITS-1:0] base;
        logic                  overflow;
    } desc_t;

    // number of outline points for a case
    function automatic logic [2:0] case_count(input logic [3:0] walls);
        logic [2:0] n;
        unique case (walls) inside
            4'd0, 4'd15:               n = 3'd0;
            4'd1, 4'd2, 4'd4, 4'd8:    n = 3'd3;
            default:                   n = 3'd4;
        endcase
        return n;
    endfunction

    // outline point i of a case
    function automatic point_t case_pt(input logic [3:0] walls, input logic [1:0] i);
        point_t p [4];
        unique case (walls) inside
            4'd1:  p = '{PT_BL, PT_BOT,   PT_LEFT,  PT_BL};
            4'd2:  p = '{PT_BR, PT_RIGHT, PT_BOT,   PT_BL};
            4'd3:  p = '{PT_BL, PT_BR,    PT_RIGHT, PT_LEFT};
            4'd4:  p = '{PT_TR, PT_TOP,   PT_RIGHT, PT_BL};
            4'd6:  p = '{PT_BR, PT_TR,    PT_TOP,   PT_BOT};
            4'd8:  p = '{PT_TL, PT_LEFT,  PT_TOP,   PT_BL};
            4'd9:  p = '{PT_BL, PT_BOT,   PT_TOP,   PT_TL};
            4'd12: p = '{PT_TL, PT_TR,    PT_RIGHT, PT_LEFT};
            4'd0, 4'd15: p = '{PT_BL, PT_BL, PT_BL, PT_BL};
            default: p = '{PT_BL, PT_BR, PT_TR, PT_TL};
        endcase
        return p[i];
    endfunction

    // vertex index to the 24-bit result field
    function automatic logic [23:0] to_idx(input logic [INDEX_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[23:0];
    endfunction

endpackage

/* rtl/msq_front.sv */
module msq_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  msq_pkg::cell_t s_data,
    input  logic           q_full,
    output logic           q_push,
    output msq_pkg::desc_t q_data
);
    import msq_pkg::*;

    logic [INDEX_BITS-1:0] next_vertex_index_reg, next_vertex_index_next;
    logic                  overflow_seen_reg, overflow_seen_next;
    logic                  accept;
    logic                  in_grid;
    logic                  emits;
    logic [2:0]            n;
    logic [INDEX_BITS-1:0] base;
    logic                  ovf_base;
    logic [INDEX_BITS:0]   sum;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // classify the cell and number its vertices
    always_comb begin
        base     = s_data.new_mesh ? '0 : next_vertex_index_reg;
        ovf_base = s_data.new_mesh ? 1'b0 : overflow_seen_reg;
        in_grid  = (32'(s_data.cell_x) <= 32'(GRID_SIZE - 2)) &&
                   (32'(s_data.cell_y) <= 32'(GRID_SIZE - 2));
        n        = case_count(s_data.corner_walls);
        emits    = in_grid && (n != 3'd0);
        sum      = {1'b0, base} + {{(INDEX_BITS - 3){1'b0}}, n, 1'b0};
        next_vertex_index_next = next_vertex_index_reg;
        overflow_seen_next     = overflow_seen_reg;
        if (accept) begin
            if (emits) begin
                next_vertex_index_next = sum[INDEX_BITS-1:0];
                overflow_seen_next     = ovf_base | sum[INDEX_BITS];
            end else begin
                next_vertex_index_next = base;
                overflow_seen_next     = ovf_base;
            end
        end
        q_push          = accept && emits;
        q_data.cell_x   = s_data.cell_x;
        q_data.cell_y   = s_data.cell_y;
        q_data.walls    = s_data.corner_walls;
        q_data.count    = n;
        q_data.base     = base;
        q_data.overflow = ovf_base | sum[INDEX_BITS];
    end

    // numbering state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_vertex_index_reg <= '0;
            overflow_seen_reg     <= 1'b0;
        end else begin
            next_vertex_index_reg <= next_vertex_index_next;
            overflow_seen_reg     <= overflow_seen_next;
        end
    end

endmodule

/* rtl/msq_queue.sv */
module msq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  msq_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output msq_pkg::desc_t head_data
);
    import msq_pkg::*;

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/msq_back.sv */
`include "marching_squares_cell_mesher_unit_defines.svh"

module msq_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  msq_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  msq_pkg::desc_t   q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output msq_pkg::result_t m_data
);
    import msq_pkg::*;

    logic [4:0]  step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    result_t     m_data_reg, m_data_next;
    logic        load;
    logic [4:0]  n5, two_n, fl_end, total, d, j, fl;
    logic        is_vertex, top, last_rec;
    logic [1:0]  i;
    logic [2:0]  nx;
    logic [3:0]  oa, ob, oc;
    point_t      pt;
    logic [8:0]  frac;
    logic [16:0] off_x, off_y, xa, ya;
    logic [26:0] prod_x, prod_y;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = load && last_rec;

    // record sequencer: decode the step into a vertex or a triangle
    always_comb begin
        n5     = {2'b00, q_data.count};
        two_n  = {1'b0, q_data.count, 1'b0};
        fl_end = two_n + ((q_data.count == 3'd4) ? 5'd2 : 5'd1);
        total  = fl_end + two_n;
        last_rec  = (step_reg == total - 5'd1);
        is_vertex = 1'b0;
        top = 1'b0;
        i   = 2'd0;
        nx  = 3'd0;
        oa  = 4'd0;
        ob  = 4'd0;
        oc  = 4'd0;
        d   = step_reg - n5;
        j   = step_reg - fl_end;
        fl  = step_reg - two_n;
        if (step_reg < n5) begin
            is_vertex = 1'b1;
            i  = step_reg[1:0];
            oa = {2'b00, i};
        end else if (step_reg < two_n) begin
            is_vertex = 1'b1;
            top = 1'b1;
            i   = d[1:0];
            oa  = {1'b0, q_data.count} + {2'b00, i};
        end else if (step_reg < fl_end) begin
            // floor triangles
            oa = 4'd0;
            ob = fl[0] ? 4'd2 : 4'd1;
            oc = fl[0] ? 4'd3 : 4'd2;
        end else begin
            // two side triangles per outline edge
            i  = j[2:1];
            nx = ({1'b0, i} == q_data.count - 3'd1) ? 3'd0 : {1'b0, i} + 3'd1;
            oa = {2'b00, i};
            if (!j[0]) begin
                ob = {1'b0, q_data.count} + {2'b00, i};
                oc = {1'b0, q_data.count} + {1'b0, nx};
            end else begin
                ob = {1'b0, q_data.count} + {1'b0, nx};
                oc = {1'b0, nx};
            end
        end
    end

    // vertex position: one multiply per axis
    always_comb begin
        pt   = case_pt(q_data.walls, i);
        frac = (cfg.edge_fraction > 9'd256) ? 9'd256 : cfg.edge_fraction;
        case (pt)
            PT_BR, PT_TR, PT_RIGHT: off_x = 17'd256;
            PT_BOT, PT_TOP:         off_x = {8'd0, frac};
            default:                off_x = 17'd0;
        endcase
        case (pt)
            PT_TR, PT_TL, PT_TOP: off_y = 17'd256;
            PT_RIGHT, PT_LEFT:    off_y = {8'd0, frac};
            default:              off_y = 17'd0;
        endcase
        xa     = {1'b0, q_data.cell_x, 8'd0} + off_x;
        ya     = {1'b0, q_data.cell_y, 8'd0} + off_y;
        prod_x = 27'(xa) * 27'(cfg.tile_size);
        prod_y = 27'(ya) * 27'(cfg.tile_size);
    end

    // result assembly
    always_comb begin
        m_data_next.kind           = is_vertex ? KIND_VERTEX : KIND_TRI;
        m_data_next.pos_x          = '0;
        m_data_next.pos_y          = '0;
        m_data_next.pos_z          = '0;
        m_data_next.uv_top         = 1'b0;
        m_data_next.index_a        = to_idx(q_data.base + INDEX_BITS'(oa));
        m_data_next.index_b        = '0;
        m_data_next.index_c        = '0;
        m_data_next.index_overflow = q_data.overflow;
        m_data_next.last           = last_rec;
        if (is_vertex) begin
            m_data_next.pos_x  = prod_x[26] ? POS_MAX : prod_x[25:0];
            m_data_next.pos_y  = prod_y[26] ? POS_MAX : prod_y[25:0];
            m_data_next.pos_z  = top ? {cfg.wall_height, 8'd0} : 24'd0;
            m_data_next.uv_top = top;
        end else begin
            m_data_next.index_b = to_idx(q_data.base + INDEX_BITS'(ob));
            m_data_next.index_c = to_idx(q_data.base + INDEX_BITS'(oc));
        end
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            step_next    = last_rec ? 5'd0 : step_reg + 5'd1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    `MSQ_ASSERT_IMP(a_step_range, q_valid, step_reg < total, "step beyond record count")
    `MSQ_ASSERT_NXT(a_pop_restart, q_pop, step_reg == 5'd0, "step not cleared after cell")
    `MSQ_ASSERT_IMP(a_last_is_tri, m_valid_reg && m_data_reg.last, m_data_reg.kind == KIND_TRI, "cell ends on a vertex record")
    `MSQ_ASSERT_IMP(a_vertex_idx, m_valid_reg && m_data_reg.kind == KIND_VERTEX, m_data_reg.index_b == 24'd0 && m_data_reg.index_c == 24'd0, "vertex record with corner indexes")

endmodule

/* rtl/marching_squares_cell_mesher_unit.sv */
// Wall mesher for marching squares: each accepted cell (coordinates, four corner
// wall flags, mesh restart) yields 13 records for a triangle case or 18 for a quad
// case, one record per cycle out of the back-end sequencer and its output register
// whenever the output is free or m_ready is high; empty, full and out-of-grid cells
// only update the vertex counter at the front. A two-entry queue between front and
// back holds the cell whose records are streaming out plus one more classified cell,
// so the input stays ready as long as the queue has room. Records come as bottom
// vertices, raised vertices, floor triangles, then two side triangles per edge, with
// the last flag on the final one. Configuration writes are accepted every cycle and
// should only be issued while no cell is in flight.
module marching_squares_cell_mesher_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  msq_pkg::cell_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output msq_pkg::result_t m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data
);
    import msq_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_full, q_push, q_pop, q_valid;
    desc_t push_data, head_data;

    assign cfg_ready = 1'b1;

    // configuration register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TILE_SIZE:     cfg_next.tile_size     = cfg_data[9:0];
                CFG_WALL_HEIGHT:   cfg_next.wall_height   = cfg_data;
                CFG_EDGE_FRACTION: cfg_next.edge_fraction = cfg_data[8:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_size     <= 10'd100;
            cfg_reg.wall_height   <= 16'd300;
            cfg_reg.edge_fraction <= 9'd128;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    msq_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (push_data)
    );

    msq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_data)
    );

    msq_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (head_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
